### rtl/kdlp_pkg.sv
// Shared types and constants for the key debounce and long-press block.
// Used by kdlp_core and key_debounce_long_press_top; no dependencies.
package kdlp_pkg;

   // Input item: a scan tick with key levels, or a read of the next event.
   typedef struct packed {
      logic action;
      logic set_key_n;
      logic start_key_n;
      logic recall_key_n;
      logic charger_n;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [3:0] event_code;
      logic [6:0] stable_keys;
   } rsp_type;

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_READ = 1'b1
   } action_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_DEBOUNCE_TICKS = 1'b0,
      CSR_HOLD_TICKS     = 1'b1
   } csr_index_type;

   localparam logic [7:0] DEBOUNCE_TICKS_RESET = 8'd5;
   localparam logic [9:0] HOLD_TICKS_RESET     = 10'd600;

   // Event codes returned on a read.
   typedef enum logic [3:0] {
      EV_NONE        = 4'd0,
      EV_START       = 4'd1,
      EV_SET         = 4'd2,
      EV_RECALL      = 4'd3,
      EV_RS_HOLD     = 4'd4,
      EV_SET_HOLD    = 4'd5,
      EV_RCL_HOLD    = 4'd6,
      EV_SS_HOLD     = 4'd7,
      EV_SR_HOLD     = 4'd8,
      EV_CHARGING    = 4'd9,
      EV_START_HOLD  = 4'd10
   } event_type;

   // Bit positions in the pending event flags, lowest bit read first.
   localparam int PEND_START      = 0;
   localparam int PEND_SET        = 1;
   localparam int PEND_RECALL     = 2;
   localparam int PEND_RS_HOLD    = 3;
   localparam int PEND_SET_HOLD   = 4;
   localparam int PEND_RCL_HOLD   = 5;
   localparam int PEND_SS_HOLD    = 6;
   localparam int PEND_SR_HOLD    = 7;
   localparam int PEND_START_HOLD = 8;
   localparam int PEND_COUNT      = 9;

   // Bit positions in the seven-bit key pattern.
   localparam int KEY_START_RECALL = 0;
   localparam int KEY_SET          = 1;
   localparam int KEY_START        = 2;
   localparam int KEY_RECALL       = 3;
   localparam int KEY_START_SET    = 4;
   localparam int KEY_RECALL_SET   = 6;

   function automatic event_type pend_code(input logic [3:0] idx);
      event_type code;
      case (idx)
         4'd0:    code = EV_START;
         4'd1:    code = EV_SET;
         4'd2:    code = EV_RECALL;
         4'd3:    code = EV_RS_HOLD;
         4'd4:    code = EV_SET_HOLD;
         4'd5:    code = EV_RCL_HOLD;
         4'd6:    code = EV_SS_HOLD;
         4'd7:    code = EV_SR_HOLD;
         4'd8:    code = EV_START_HOLD;
         default: code = EV_NONE;
      endcase
      return code;
   endfunction

endpackage

### rtl/kdlp_core.sv
// Debounce, hold timing and pending event state, plus the two configuration
// registers. Computes the result of one item combinationally. Uses kdlp_pkg.
module kdlp_core import kdlp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  req_type    item,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [9:0] csr_data,
   output rsp_type    result
);

   logic [7:0]  debounce_ticks_ff, debounce_ticks_in;
   logic [9:0]  hold_ticks_ff, hold_ticks_in;
   logic [6:0]  previous_pattern_ff, previous_pattern_in;
   logic [7:0]  stable_count_ff, stable_count_in;
   logic [6:0]  accepted_pattern_ff, accepted_pattern_in;
   logic [6:0]  last_accepted_ff, last_accepted_in;
   logic [10:0] hold_count_ff, hold_count_in;
   logic [8:0]  pending_ff, pending_in;

   logic        set_dn, start_dn, recall_dn;
   logic [6:0]  cur;
   logic [7:0]  sc_inc;
   logic [6:0]  acc_next;
   logic [6:0]  released;
   logic [10:0] hold_limit;
   logic [10:0] hold_mid;
   logic [8:0]  latch_bits;
   logic [3:0]  first_idx;
   logic        any_pending;
   event_type   code;

   always_comb begin
      debounce_ticks_in = debounce_ticks_ff;
      hold_ticks_in     = hold_ticks_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_TICKS: debounce_ticks_in = csr_data[7:0];
            CSR_HOLD_TICKS:     hold_ticks_in     = csr_data;
            default:            ;
         endcase
      end
   end

   assign set_dn    = !item.set_key_n;
   assign start_dn  = !item.start_key_n;
   assign recall_dn = !item.recall_key_n;

   always_comb begin
      cur = '0;
      cur[KEY_START_RECALL] = start_dn && recall_dn;
      cur[KEY_SET]          = set_dn;
      cur[KEY_START]        = start_dn;
      cur[KEY_RECALL]       = recall_dn;
      cur[KEY_START_SET]    = start_dn && set_dn;
      cur[KEY_RECALL_SET]   = recall_dn && set_dn;
   end

   assign hold_limit = {1'b0, hold_ticks_ff} + 11'd1;

   // Scan tick: debounce, then hold timing on the accepted pattern.
   always_comb begin
      sc_inc     = (stable_count_ff != 8'hFF) ? stable_count_ff + 8'd1 : stable_count_ff;
      acc_next   = accepted_pattern_ff;
      released   = '0;
      latch_bits = '0;
      hold_mid   = hold_count_ff;
      previous_pattern_in = previous_pattern_ff;
      stable_count_in     = stable_count_ff;
      last_accepted_in    = last_accepted_ff;
      hold_count_in       = hold_count_ff;

      if (cur != previous_pattern_ff) begin
         stable_count_in     = '0;
         previous_pattern_in = cur;
      end else begin
         stable_count_in = sc_inc;
         if (sc_inc >= debounce_ticks_ff) begin
            stable_count_in  = debounce_ticks_ff;
            acc_next         = previous_pattern_ff;
            released         = last_accepted_ff & ~previous_pattern_ff;
            last_accepted_in = previous_pattern_ff;
         end

         if (hold_count_ff == {1'b0, hold_ticks_ff}) begin
            if (cur[KEY_START_RECALL])          latch_bits[PEND_SR_HOLD]    = 1'b1;
            else if (acc_next[KEY_START_SET])   latch_bits[PEND_SS_HOLD]    = 1'b1;
            else if (cur[KEY_RECALL_SET])       latch_bits[PEND_RS_HOLD]    = 1'b1;
            else if (acc_next[KEY_SET])         latch_bits[PEND_SET_HOLD]   = 1'b1;
            else if (acc_next[KEY_START])       latch_bits[PEND_START_HOLD] = 1'b1;
            else if (acc_next[KEY_RECALL])      latch_bits[PEND_RCL_HOLD]   = 1'b1;
            hold_mid = hold_limit;
         end else if (hold_count_ff < {1'b0, hold_ticks_ff}) begin
            if (released[KEY_SET])              latch_bits[PEND_SET]    = 1'b1;
            else if (released[KEY_START])       latch_bits[PEND_START]  = 1'b1;
            else if (released[KEY_RECALL])      latch_bits[PEND_RECALL] = 1'b1;
         end else begin
            hold_mid = hold_limit;
         end

         if (acc_next[KEY_SET] || acc_next[KEY_START] || acc_next[KEY_RECALL]) begin
            hold_count_in = hold_mid + 11'd1;
         end else begin
            hold_count_in = '0;
         end
      end
   end

   // Read: lowest pending flag wins.
   always_comb begin
      first_idx = '0;
      for (int i = PEND_COUNT - 1; i >= 0; i--) begin
         if (pending_ff[i]) first_idx = 4'(i);
      end
   end

   assign any_pending = |pending_ff;

   always_comb begin
      code       = EV_NONE;
      pending_in = pending_ff;
      if (item.action == ACT_READ) begin
         if (any_pending) begin
            code = pend_code(first_idx);
            pending_in[first_idx] = 1'b0;
         end else if (!item.charger_n) begin
            code = EV_CHARGING;
         end
      end else begin
         pending_in = pending_ff | latch_bits;
      end
   end

   always_comb begin
      result.event_code  = code;
      result.stable_keys = (item.action == ACT_READ) ? accepted_pattern_ff : acc_next;
   end

   assign accepted_pattern_in = acc_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= DEBOUNCE_TICKS_RESET;
         hold_ticks_ff       <= HOLD_TICKS_RESET;
         previous_pattern_ff <= '0;
         stable_count_ff     <= '0;
         accepted_pattern_ff <= '0;
         last_accepted_ff    <= '0;
         hold_count_ff       <= '0;
         pending_ff          <= '0;
      end else begin
         debounce_ticks_ff <= debounce_ticks_in;
         hold_ticks_ff     <= hold_ticks_in;
         if (step) begin
            pending_ff <= pending_in;
            if (item.action == ACT_TICK) begin
               previous_pattern_ff <= previous_pattern_in;
               stable_count_ff     <= stable_count_in;
               accepted_pattern_ff <= accepted_pattern_in;
               last_accepted_ff    <= last_accepted_in;
               hold_count_ff       <= hold_count_in;
            end
         end
      end
   end

   // A read never touches the debounce or hold state.
   assert property (@(posedge clock) disable iff (reset)
      step && item.action == ACT_READ |=> $stable(hold_count_ff) && $stable(accepted_pattern_ff))
      else $error("read item changed key state");

   // The last accepted pattern always tracks the accepted pattern.
   assert property (@(posedge clock) disable iff (reset)
      last_accepted_ff == accepted_pattern_ff)
      else $error("last accepted pattern diverged");

   // A tick never clears a pending event.
   assert property (@(posedge clock) disable iff (reset)
      step && item.action == ACT_TICK |=> (pending_ff & $past(pending_ff)) == $past(pending_ff))
      else $error("tick cleared a pending event");

endmodule

### rtl/key_debounce_long_press_top.sv
// Key debounce with long-press detection: input register, core, result register.
// Each item passes from the input register through kdlp_core into the result register;
// throughput: one item per cycle while the result register is empty or rsp_ready is high.
// kdlp_core computes each result combinationally. A stalled result holds back at most one item.
// Synchronous active-high reset clears the valid flags and core state; debounce_ticks
// resets to 5 and hold_ticks to 600. Configuration writes are taken every cycle.
module key_debounce_long_press_top import kdlp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [9:0] csr_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type core_result;
   logic    advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   kdlp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_data_ff),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .result    (core_result)
   );

   assign in_valid_in  = req_valid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
      if (advance) out_data_ff <= core_result;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Pair bits imply both of their single-key bits, and the unused bit 5 stays clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (!rsp_data.stable_keys[KEY_START_RECALL] ||
            (rsp_data.stable_keys[KEY_START] && rsp_data.stable_keys[KEY_RECALL])) &&
         (!rsp_data.stable_keys[KEY_START_SET] ||
            (rsp_data.stable_keys[KEY_START] && rsp_data.stable_keys[KEY_SET])) &&
         (!rsp_data.stable_keys[KEY_RECALL_SET] ||
            (rsp_data.stable_keys[KEY_RECALL] && rsp_data.stable_keys[KEY_SET])) &&
         !rsp_data.stable_keys[5])
      else $error("inconsistent stable key pattern");

   // A scan tick always reports no event.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.action == ACT_TICK |=> rsp_data.event_code == EV_NONE)
      else $error("tick produced an event code");

   // Every transfer into the result register comes from a held input item.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid && (!$past(in_valid_ff) == 1'b0))
      else $error("result without input item");

   // An empty input register always takes a new item.
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stalled while empty");

endmodule
